// ===== src/lsq_pkg.sv =====
// Shared constants for the least-squares line fit block.
package lsq_pkg;

    localparam int DEF_MAX_POINTS   = 4096;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 8;

    localparam int WIDE_W  = 128;
    localparam int QUOT_W  = 41;
    localparam int ITER_W  = 8;
    localparam int STEP_W  = 4;

    localparam logic [1:0] FIT_OK       = 2'd0;
    localparam logic [1:0] FIT_SINGULAR = 2'd1;
    localparam logic [1:0] FIT_CONST_Y  = 2'd2;
    localparam logic [1:0] FIT_OVERFLOW = 2'd3;

    localparam logic [STEP_W-1:0] MUL_STEPS = 4'd10;
    localparam logic [STEP_W-1:0] DIV_SLOPE = 4'd0;
    localparam logic [STEP_W-1:0] DIV_ICPT  = 4'd1;
    localparam logic [STEP_W-1:0] DIV_R2    = 4'd2;

endpackage

// ===== src/least_squares_line_fit.sv =====
// Least-squares line fit: running sums, shared multiplier and divider, result register.
//
// Input transactions carry x_sample, y_sample and last_point on in_valid/in_ready.
// Each accepted pair is added to the count and the five sums: the accept cycle
// adds x, y and the count, then one small signed multiplier forms x*x, y*y and
// x*y in turn. A pair that arrives with MAX_POINTS pairs already kept is dropped
// and flags the overflow status.
// A pair with last_point set starts the fit. One 128-bit shift-add multiplier
// forms ten products, one multiplier bit per cycle and stopping when the rest of
// the multiplier is zero. Unless the fit is singular, one restoring divider then
// forms slope, intercept and, if y is not constant, R squared at one quotient
// bit per cycle.
// in_ready is high only while the block waits for a pair. The result transaction
// sits in an output register on out_valid/out_ready; accumulation of the next
// set goes on while it waits, and a following fit holds its result until the
// register is free. The sums clear when a result is loaded.
// Reset clears the sums, the count, the status and the output register.
module least_squares_line_fit
    import lsq_pkg::*;
#(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] x_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] y_sample,
    input  logic                           last_point,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [31:0]             slope,
    output logic signed [31:0]             intercept,
    output logic        [16:0]             r_squared,
    output logic        [1:0]              fit_status
);

    localparam int W   = WIDE_W;
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int SXW = SAMPLE_WIDTH + CW;
    localparam int SQW = 2 * SAMPLE_WIDTH + CW - 2;
    localparam int SPW = 2 * SAMPLE_WIDTH + CW - 1;
    localparam int PW  = 2 * SAMPLE_WIDTH;
    localparam logic [CW-1:0]     CAP      = CW'(MAX_POINTS);
    localparam logic [ITER_W-1:0] IT_SLOPE = ITER_W'(W + 17);
    localparam logic [ITER_W-1:0] IT_ICPT  = ITER_W'(W + 17 - FRAC_BITS);
    localparam logic [QUOT_W:0]   Q_CAP    = (QUOT_W+1)'(1) << (QUOT_W - 1);
    localparam logic signed [QUOT_W+1:0] S32_MAX = (QUOT_W+2)'(32'h7FFF_FFFF);
    localparam logic signed [QUOT_W+1:0] S32_MIN = -(QUOT_W+2)'(33'h0_8000_0000);
    localparam logic signed [QUOT_W+1:0] R2_MAX  = (QUOT_W+2)'(65536);

    typedef enum logic [3:0] {
        S_IDLE, S_ACC, S_MLOAD, S_MUL, S_MWB, S_CHECK, S_DLOAD, S_DIV, S_DFIN, S_DONE
    } state_t;

    state_t state_reg;
    logic [STEP_W-1:0] step_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_reg, y_reg;
    logic last_reg;

    logic [CW-1:0]         count_reg;
    logic signed [SXW-1:0] sum_x_reg, sum_y_reg;
    logic [SQW-1:0]        sum_xx_reg, sum_yy_reg;
    logic signed [SPW-1:0] sum_xy_reg;
    logic                  ovf_reg;

    logic [W-1:0] t_reg, dxx_reg, dxy_reg, dyy_reg, nb_reg, rd_reg;
    logic [W-1:0] ma_reg, mb_reg, macc_reg;
    logic         mneg_reg;

    logic [W-1:0]        dn_reg, dd_reg, rem_reg;
    logic [QUOT_W-1:0]   q_reg;
    logic                qsat_reg, dneg_reg;
    logic [ITER_W-1:0]   iter_reg;

    logic signed [31:0] res_slope_reg, res_icpt_reg;
    logic [16:0]        res_r2_reg;
    logic [1:0]         res_status_reg;

    logic signed [31:0] slope_reg, intercept_reg;
    logic [16:0]        r2_reg;
    logic [1:0]         status_reg;
    logic               out_valid_reg;

    logic signed [SAMPLE_WIDTH-1:0] op_a, op_b;
    logic [PW-1:0] prod;
    logic [W-1:0]  opa_w, opb_w, opb_mag;
    logic [W-1:0]  prod_w, diff_w;
    logic [W:0]    remsh, rsub;
    logic          rge;
    logic [QUOT_W:0]         qr, qmag;
    logic signed [QUOT_W+1:0] qval;
    logic signed [31:0]      qsat32;
    logic [16:0]             qr2;
    logic                    singular, ynull;
    logic                    load_out;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign slope      = slope_reg;
    assign intercept  = intercept_reg;
    assign r_squared  = r2_reg;
    assign fit_status = status_reg;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    begin op_a = x_reg; op_b = x_reg; end
            2'd1:    begin op_a = y_reg; op_b = y_reg; end
            default: begin op_a = x_reg; op_b = y_reg; end
        endcase
        prod = PW'(op_a * op_b);
    end

    always_comb
    begin
        case (step_reg)
            4'd0:    begin opa_w = W'(count_reg);           opb_w = W'(sum_xx_reg); end
            4'd1:    begin opa_w = W'(sum_x_reg);           opb_w = W'(sum_x_reg); end
            4'd2:    begin opa_w = W'(count_reg);           opb_w = W'(sum_xy_reg); end
            4'd3:    begin opa_w = W'(sum_x_reg);           opb_w = W'(sum_y_reg); end
            4'd4:    begin opa_w = W'(count_reg);           opb_w = W'(sum_yy_reg); end
            4'd5:    begin opa_w = W'(sum_y_reg);           opb_w = W'(sum_y_reg); end
            4'd6:    begin opa_w = W'(sum_xx_reg);          opb_w = W'(sum_y_reg); end
            4'd7:    begin opa_w = W'(sum_x_reg);           opb_w = W'(sum_xy_reg); end
            4'd8:    begin opa_w = dxy_reg;                 opb_w = dxy_reg; end
            default: begin opa_w = dxx_reg;                 opb_w = dyy_reg; end
        endcase
        opb_mag = opb_w[W-1] ? (~opb_w + W'(1)) : opb_w;
    end

    always_comb
    begin
        prod_w = mneg_reg ? (~macc_reg + W'(1)) : macc_reg;
        diff_w = mneg_reg ? (t_reg + macc_reg) : (t_reg - macc_reg);
    end

    always_comb
    begin
        remsh = {rem_reg, dn_reg[W-1]};
        rsub  = remsh - {1'b0, dd_reg};
        rge   = !rsub[W];
    end

    always_comb
    begin
        qr   = ({1'b0, q_reg} + (QUOT_W+1)'(1)) >> 1;
        qmag = (qsat_reg || qr > Q_CAP) ? Q_CAP : qr;
        qval = dneg_reg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
        if (qval > S32_MAX)
        begin
            qsat32 = 32'sh7FFF_FFFF;
        end
        else if (qval < S32_MIN)
        begin
            qsat32 = -32'sh7FFF_FFFF - 32'sd1;
        end
        else
        begin
            qsat32 = qval[31:0];
        end
        if (qval < 0)
        begin
            qr2 = 17'd0;
        end
        else if (qval > R2_MAX)
        begin
            qr2 = 17'd65536;
        end
        else
        begin
            qr2 = qval[16:0];
        end
    end

    assign singular = (count_reg < CW'(2)) || (dxx_reg == '0) || dxx_reg[W-1];
    assign ynull    = (dyy_reg == '0) || dyy_reg[W-1];
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            last_reg       <= 1'b0;
            count_reg      <= '0;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            sum_xx_reg     <= '0;
            sum_yy_reg     <= '0;
            sum_xy_reg     <= '0;
            ovf_reg        <= 1'b0;
            t_reg          <= '0;
            dxx_reg        <= '0;
            dxy_reg        <= '0;
            dyy_reg        <= '0;
            nb_reg         <= '0;
            rd_reg         <= '0;
            ma_reg         <= '0;
            mb_reg         <= '0;
            macc_reg       <= '0;
            mneg_reg       <= 1'b0;
            dn_reg         <= '0;
            dd_reg         <= '0;
            rem_reg        <= '0;
            q_reg          <= '0;
            qsat_reg       <= 1'b0;
            dneg_reg       <= 1'b0;
            iter_reg       <= '0;
            res_slope_reg  <= '0;
            res_icpt_reg   <= '0;
            res_r2_reg     <= '0;
            res_status_reg <= FIT_OK;
            slope_reg      <= '0;
            intercept_reg  <= '0;
            r2_reg         <= '0;
            status_reg     <= FIT_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg    <= x_sample;
                        y_reg    <= y_sample;
                        last_reg <= last_point;
                        step_reg <= '0;
                        if (count_reg < CAP)
                        begin
                            count_reg <= count_reg + CW'(1);
                            sum_x_reg <= sum_x_reg + SXW'(x_sample);
                            sum_y_reg <= sum_y_reg + SXW'(y_sample);
                            state_reg <= S_ACC;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                            if (last_point)
                            begin
                                state_reg <= S_MLOAD;
                            end
                        end
                    end
                end
                S_ACC:
                begin
                    case (step_reg[1:0])
                        2'd0:    sum_xx_reg <= sum_xx_reg + SQW'(prod);
                        2'd1:    sum_yy_reg <= sum_yy_reg + SQW'(prod);
                        default: sum_xy_reg <= sum_xy_reg + SPW'($signed(prod));
                    endcase
                    if (step_reg[1:0] == 2'd2)
                    begin
                        step_reg  <= '0;
                        state_reg <= last_reg ? S_MLOAD : S_IDLE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                S_MLOAD:
                begin
                    ma_reg    <= opa_w;
                    mb_reg    <= opb_mag;
                    mneg_reg  <= opb_w[W-1];
                    macc_reg  <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mb_reg == '0)
                    begin
                        state_reg <= S_MWB;
                    end
                    else
                    begin
                        if (mb_reg[0])
                        begin
                            macc_reg <= macc_reg + ma_reg;
                        end
                        ma_reg <= ma_reg << 1;
                        mb_reg <= mb_reg >> 1;
                    end
                end
                S_MWB:
                begin
                    case (step_reg)
                        4'd1:    dxx_reg <= diff_w;
                        4'd3:    dxy_reg <= diff_w;
                        4'd5:    dyy_reg <= diff_w;
                        4'd7:    nb_reg  <= diff_w;
                        4'd9:    rd_reg  <= prod_w;
                        default: t_reg   <= prod_w;
                    endcase
                    if (step_reg == MUL_STEPS - STEP_W'(1))
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        step_reg  <= step_reg + STEP_W'(1);
                        state_reg <= S_MLOAD;
                    end
                end
                S_CHECK:
                begin
                    res_slope_reg <= '0;
                    res_icpt_reg  <= '0;
                    res_r2_reg    <= '0;
                    step_reg      <= DIV_SLOPE;
                    if (singular)
                    begin
                        res_status_reg <= FIT_SINGULAR;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (ovf_reg)
                        begin
                            res_status_reg <= FIT_OVERFLOW;
                        end
                        else if (ynull)
                        begin
                            res_status_reg <= FIT_CONST_Y;
                        end
                        else
                        begin
                            res_status_reg <= FIT_OK;
                        end
                        state_reg <= S_DLOAD;
                    end
                end
                S_DLOAD:
                begin
                    rem_reg  <= '0;
                    q_reg    <= '0;
                    qsat_reg <= 1'b0;
                    case (step_reg)
                        DIV_SLOPE:
                        begin
                            dneg_reg <= dxy_reg[W-1];
                            dn_reg   <= dxy_reg[W-1] ? (~dxy_reg + W'(1)) : dxy_reg;
                            dd_reg   <= dxx_reg;
                            iter_reg <= IT_SLOPE;
                        end
                        DIV_ICPT:
                        begin
                            dneg_reg <= nb_reg[W-1];
                            dn_reg   <= nb_reg[W-1] ? (~nb_reg + W'(1)) : nb_reg;
                            dd_reg   <= dxx_reg;
                            iter_reg <= IT_ICPT;
                        end
                        default:
                        begin
                            dneg_reg <= t_reg[W-1];
                            dn_reg   <= t_reg[W-1] ? (~t_reg + W'(1)) : t_reg;
                            dd_reg   <= rd_reg;
                            iter_reg <= IT_SLOPE;
                        end
                    endcase
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rge ? rsub[W-1:0] : remsh[W-1:0];
                    dn_reg   <= dn_reg << 1;
                    if (q_reg[QUOT_W-1])
                    begin
                        qsat_reg <= 1'b1;
                    end
                    else
                    begin
                        q_reg <= {q_reg[QUOT_W-2:0], rge};
                    end
                    iter_reg <= iter_reg - ITER_W'(1);
                    if (iter_reg == ITER_W'(1))
                    begin
                        state_reg <= S_DFIN;
                    end
                end
                S_DFIN:
                begin
                    case (step_reg)
                        DIV_SLOPE:
                        begin
                            res_slope_reg <= qsat32;
                            step_reg      <= DIV_ICPT;
                            state_reg     <= S_DLOAD;
                        end
                        DIV_ICPT:
                        begin
                            res_icpt_reg <= qsat32;
                            step_reg     <= DIV_R2;
                            state_reg    <= ynull ? S_DONE : S_DLOAD;
                        end
                        default:
                        begin
                            res_r2_reg <= qr2;
                            state_reg  <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (load_out)
                    begin
                        slope_reg     <= res_slope_reg;
                        intercept_reg <= res_icpt_reg;
                        r2_reg        <= res_r2_reg;
                        status_reg    <= res_status_reg;
                        count_reg     <= '0;
                        sum_x_reg     <= '0;
                        sum_y_reg     <= '0;
                        sum_xx_reg    <= '0;
                        sum_yy_reg    <= '0;
                        sum_xy_reg    <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== verif/least_squares_line_fit_tb.sv =====
// Testbench for least_squares_line_fit: directed and random point sets checked against a line-fit predictor.
module least_squares_line_fit_tb;
    import lsq_pkg::*;

    localparam int NUM_POINTS_CAP = DEF_MAX_POINTS;
    localparam int IDLE_LIMIT     = 20000;
    localparam int LONG_HOLD      = 3000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               drain;
    } point_t;

    typedef struct {
        logic signed [31:0] slope;
        logic signed [31:0] intercept;
        logic [16:0]        r_squared;
        logic [1:0]         fit_status;
    } fit_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] x_sample;
    logic signed [15:0] y_sample;
    logic last_point;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic [16:0] r_squared;
    logic [1:0] fit_status;

    point_t pending_points[$];
    fit_t   expected_fits[$];

    int  fits_checked;
    int  errors;
    int  status_seen[4];
    int  send_gap;
    int  hold_cycles;
    int  idle_cycles;
    bit  quiet;
    bit  long_hold_req;
    bit  drain_wait;
    bit  in_taken;
    bit  timed_out;

    int unsigned       acc_count;
    longint            acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    bit                acc_overflow;

    least_squares_line_fit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_sample   (x_sample),
        .y_sample   (y_sample),
        .last_point (last_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .slope      (slope),
        .intercept  (intercept),
        .r_squared  (r_squared),
        .fit_status (fit_status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Rounded scaled quotient, ties away from zero, magnitude capped at 2^40.
    function automatic longint scaled_quotient(logic signed [127:0] num,
                                               logic signed [127:0] den, int k);
        logic [127:0] mag;
        logic [255:0] q;
        bit           neg;
        neg = num[127];
        mag = neg ? -num : num;
        q = ({128'd0, mag} << (k + 1)) / {128'd0, den};
        q = (q + 1) >> 1;
        if (q > (256'd1 << 40))
            q = 256'd1 << 40;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic fit_t solve_line();
        fit_t               f;
        logic signed [127:0] n, sx, sy, sxx, syy, sxy, dxx, dxy, dyy, nb;
        longint             r;
        n   = 128'(acc_count);
        sx  = 128'(acc_x);
        sy  = 128'(acc_y);
        sxx = 128'(acc_xx);
        syy = 128'(acc_yy);
        sxy = 128'(acc_xy);
        dxx = n * sxx - sx * sx;
        dxy = n * sxy - sx * sy;
        dyy = n * syy - sy * sy;
        f.slope = '0;
        f.intercept = '0;
        f.r_squared = '0;
        if (acc_count < 2 || dxx <= 0)
        begin
            f.fit_status = FIT_SINGULAR;
        end
        else
        begin
            f.slope = clip32(scaled_quotient(dxy, dxx, 16));
            nb = sxx * sy - sx * sxy;
            f.intercept = clip32(scaled_quotient(nb, dxx, 16 - DEF_FRAC_BITS));
            if (dyy <= 0)
            begin
                f.fit_status = acc_overflow ? FIT_OVERFLOW : FIT_CONST_Y;
            end
            else
            begin
                r = scaled_quotient(dxy * dxy, dxx * dyy, 16);
                if (r < 0)
                    r = 0;
                if (r > 65536)
                    r = 65536;
                f.r_squared = r[16:0];
                f.fit_status = acc_overflow ? FIT_OVERFLOW : FIT_OK;
            end
        end
        return f;
    endfunction

    task automatic accumulate_point(point_t p);
        longint x, y;
        x = p.x;
        y = p.y;
        if (acc_count < NUM_POINTS_CAP)
        begin
            acc_count++;
            acc_x  += x;
            acc_y  += y;
            acc_xx += x * x;
            acc_yy += y * y;
            acc_xy += x * y;
        end
        else
        begin
            acc_overflow = 1'b1;
        end
        if (p.last)
        begin
            expected_fits = {expected_fits, solve_line()};
            acc_count = 0;
            acc_x = 0;
            acc_y = 0;
            acc_xx = 0;
            acc_yy = 0;
            acc_xy = 0;
            acc_overflow = 1'b0;
        end
    endtask

    function automatic logic signed [15:0] pick_value(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15)) - 16'sd8;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 600)) - 16'sd300;
        endcase
    endfunction

    // Queue one point set; x_mode/y_mode pick the value spread, fixed modes hold one value.
    task automatic queue_set(int count, int x_mode, int y_mode, bit drain);
        point_t             p;
        logic signed [15:0] fx, fy;
        fx = pick_value(0);
        fy = pick_value(0);
        for (int i = 0; i < count; i++)
        begin
            p.x = (x_mode == 9) ? fx : pick_value(x_mode);
            p.y = (y_mode == 9) ? fy : pick_value(y_mode);
            p.last = (i == count - 1);
            p.drain = drain && (i == 0);
            pending_points = {pending_points, p};
        end
    endtask

    task automatic queue_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
        point_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        p.drain = 1'b0;
        pending_points = {pending_points, p};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
        end
    end

    always @(negedge clk)
    begin
        point_t p;
        logic   next_valid;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            x_sample <= '0;
            y_sample <= '0;
            last_point <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            next_valid = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
            end
            else if (pending_points.size() > 0)
            begin
                if (pending_points[0].drain && expected_fits.size() > 0)
                begin
                    drain_wait = 1'b1;
                end
                else
                begin
                    p = pending_points.pop_front();
                    x_sample <= p.x;
                    y_sample <= p.y;
                    last_point <= p.last;
                    next_valid = 1'b1;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 11);
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_cycles = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                hold_cycles = $urandom_range(1, 11);
        end
    end

    always @(posedge clk)
    begin
        fit_t e;
        point_t p;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                p.x = x_sample;
                p.y = y_sample;
                p.last = last_point;
                p.drain = 1'b0;
                accumulate_point(p);
            end
            if (out_valid && out_ready)
            begin
                if (expected_fits.size() == 0)
                begin
                    $display("%0t: unexpected result slope=%0d intercept=%0d r2=%0d status=%0d",
                             $time, slope, intercept, r_squared, fit_status);
                    errors++;
                end
                else
                begin
                    e = expected_fits.pop_front();
                    fits_checked++;
                    status_seen[fit_status]++;
                    if (slope !== e.slope)
                    begin
                        $display("%0t: slope expected %0d actual %0d", $time, e.slope, slope);
                        errors++;
                    end
                    if (intercept !== e.intercept)
                    begin
                        $display("%0t: intercept expected %0d actual %0d",
                                 $time, e.intercept, intercept);
                        errors++;
                    end
                    if (r_squared !== e.r_squared)
                    begin
                        $display("%0t: r_squared expected %0d actual %0d",
                                 $time, e.r_squared, r_squared);
                        errors++;
                    end
                    if (fit_status !== e.fit_status)
                    begin
                        $display("%0t: fit_status expected %0d actual %0d",
                                 $time, e.fit_status, fit_status);
                        errors++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT && !timed_out)
            begin
                timed_out = 1'b1;
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("least_squares_line_fit test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int sent;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        x_sample = '0;
        y_sample = '0;
        last_point = 1'b0;
        out_ready = 1'b0;
        send_gap = 0;
        hold_cycles = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        long_hold_req = 1'b0;
        drain_wait = 1'b0;
        timed_out = 1'b0;
        errors = 0;
        fits_checked = 0;
        acc_count = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xx = 0;
        acc_yy = 0;
        acc_xy = 0;
        acc_overflow = 1'b0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed sets: single point, extremes, equal x, constant y, exact line.
        queue_point(16'sh7fff, 16'sh8000, 1'b1);
        queue_point(16'sh8000, 16'sh8000, 1'b0);
        queue_point(16'sh7fff, 16'sh7fff, 1'b1);
        queue_point(16'sh8000, 16'sh7fff, 1'b0);
        queue_point(16'sh7fff, 16'sh8000, 1'b0);
        queue_point(16'sh0000, 16'sh0000, 1'b1);
        queue_point(16'sh0100, 16'sh0005, 1'b0);
        queue_point(16'sh0100, 16'sh0300, 1'b0);
        queue_point(16'sh0100, 16'sh8000, 1'b1);
        queue_point(16'sh0001, 16'sh0200, 1'b0);
        queue_point(16'sh0002, 16'sh0200, 1'b0);
        queue_point(16'sh0003, 16'sh0200, 1'b1);
        queue_point(16'sh0000, 16'sh0100, 1'b0);
        queue_point(16'sh0100, 16'sh0300, 1'b0);
        queue_point(16'sh0200, 16'sh0500, 1'b1);
        queue_point(16'sh0000, 16'sh7fff, 1'b0);
        queue_point(16'sh0001, 16'sh8000, 1'b1);
        queue_point(16'sh7fff, 16'sh0001, 1'b0);
        queue_point(16'sh7ffe, 16'sh0003, 1'b0);
        queue_point(16'sh8000, 16'sh0002, 1'b1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // One set beyond capacity, then another with constant y beyond capacity.
        queue_set(NUM_POINTS_CAP + 5, 0, 0, 1'b1);
        queue_set(NUM_POINTS_CAP + 2, 3, 9, 1'b1);

        sent = 0;
        while (sent < 1800)
        begin
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            queue_set(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3),
                      $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 3) == 0 ? 9 :
                      $urandom_range(1, 3)), $urandom_range(0, 39) == 0);
            if ($urandom_range(0, 29) == 0)
                queue_set(n, 9, 0, 1'b0);
            sent += n;
        end

        wait (pending_points.size() < 1400);
        long_hold_req = 1'b1;
        wait (pending_points.size() < 300);
        quiet = 1'b1;
        wait (pending_points.size() == 0 && !in_valid);
        wait (expected_fits.size() == 0);
        repeat (2000) @(posedge clk);

        $display("Checked %0d fits: %0d ok, %0d singular, %0d constant y, %0d over capacity.",
                 fits_checked, status_seen[FIT_OK], status_seen[FIT_SINGULAR],
                 status_seen[FIT_CONST_Y], status_seen[FIT_OVERFLOW]);
        if (errors == 0 && expected_fits.size() == 0)
        begin
            $display("least_squares_line_fit test passed");
        end
        else
        begin
            $display("%0d mismatches, %0d fits still expected", errors, expected_fits.size());
            $display("least_squares_line_fit test failed");
        end
        $finish;
    end

endmodule
